// ===== rtl/pgf_pkg.sv =====
`default_nettype none
package pgf_pkg;

  localparam int FracBits = 16;
  localparam int GFrac    = 24;
  localparam int CoordW   = 32;
  localparam int ForceW   = 48;
  localparam int MagW     = ForceW - 1;
  // G * m1 * m2 * |a| is 128 bits before the fraction shift.
  localparam int NumW     = 128 + FracBits;
  // The cube of a 33-bit root is 99 bits, then scaled by G's fraction.
  localparam int DenW     = 99 + GFrac;
  localparam int CmpW     = DenW + MagW;
  localparam int RadW     = 65;
  localparam int RootW    = 33;

  localparam logic [31:0]     GravReset = 32'd16777216;
  localparam logic [MagW-1:0] ForceMax  = '1;

endpackage
`default_nettype wire

// ===== rtl/pgf_in_if.sv =====
`default_nettype none
interface pgf_in_if;
  import pgf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] first_x;
  logic signed [CoordW-1:0] first_y;
  logic signed [CoordW-1:0] second_x;
  logic signed [CoordW-1:0] second_y;
  logic [CoordW-1:0]        first_mass;
  logic [CoordW-1:0]        second_mass;
  logic [CoordW-1:0]        first_radius;
  logic [CoordW-1:0]        second_radius;

  modport source (
    output valid, first_x, first_y, second_x, second_y,
    output first_mass, second_mass, first_radius, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, second_x, second_y,
    input  first_mass, second_mass, first_radius, second_radius,
    output ready
  );

endinterface
`default_nettype wire

// ===== rtl/pgf_out_if.sv =====
`default_nettype none
interface pgf_out_if;
  import pgf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ForceW-1:0] force_one_x;
  logic signed [ForceW-1:0] force_one_y;
  logic signed [ForceW-1:0] force_two_x;
  logic signed [ForceW-1:0] force_two_y;
  logic                     force_applied;
  logic                     saturated;

  modport source (
    output valid, force_one_x, force_one_y, force_two_x, force_two_y,
    output force_applied, saturated,
    input  ready
  );
  modport sink (
    input  valid, force_one_x, force_one_y, force_two_x, force_two_y,
    input  force_applied, saturated,
    output ready
  );

endinterface
`default_nettype wire

// ===== rtl/pgf_isqrt.sv =====
`default_nettype none
module pgf_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [pgf_pkg::RadW-1:0]   rad_i,
  output logic [pgf_pkg::RootW-1:0]  root_o
);
  import pgf_pkg::*;

  localparam int RemW = 2 * RootW + 1;

  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  // One root bit per stage. The remainder holds x - root^2, so setting bit b
  // costs root * 2^(b+1) + 2^(2b), since the root has no bits below b yet.
  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int B = RootW - 1 - j;
    logic [RemW-1:0]  rem_in;
    logic [RemW-1:0]  trial;
    logic [RootW-1:0] root_in;

    if (j == 0) begin : g_first
      assign rem_in  = RemW'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign trial = (RemW'(root_in) << (B + 1)) + (RemW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[j]  <= rem_in - trial;
          root_q[j] <= root_in | (RootW'(1) << B);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule
`default_nettype wire

// ===== rtl/pgf_div.sv =====
`default_nettype none
module pgf_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [pgf_pkg::NumW-1:0]  num_i,
  input  logic [pgf_pkg::DenW-1:0]  den_i,
  output logic [pgf_pkg::MagW-1:0]  quot_o
);
  import pgf_pkg::*;

  logic [NumW-1:0] rem_q [MagW];
  logic [DenW-1:0] den_q [MagW];
  logic [MagW-1:0] quo_q [MagW];

  // Restoring division, one quotient bit per stage from the top down. The
  // caller checks for a quotient of 2^MagW or more, so the top bits are zero.
  for (genvar k = 0; k < MagW; k++) begin : g_stage
    localparam int B = MagW - 1 - k;
    logic [NumW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [MagW-1:0] quo_in;
    logic [CmpW-1:0] trial;
    logic [CmpW-1:0] rem_ext;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial   = CmpW'(den_in) << B;
    assign rem_ext = CmpW'(rem_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
        if (rem_ext >= trial) begin
          rem_q[k] <= NumW'(rem_ext - trial);
          quo_q[k] <= quo_in | (MagW'(1) << B);
        end else begin
          rem_q[k] <= rem_in;
          quo_q[k] <= quo_in;
        end
      end
    end
  end

  assign quot_o = quo_q[MagW-1];

endmodule
`default_nettype wire

// ===== rtl/pair_gravity_force.sv =====
`default_nettype none
// Newtonian gravity between two 2-D bodies. Each input beat carries one pair
// of bodies; the result beat gives the force on body one, G*m1*m2*r/|r|^3 in
// signed Q32.16 saturated to +/-(2^47-1), the exact negation for body two,
// and flags for separation and clipping. Bodies whose centres are not
// strictly farther apart than the sum of their radii get zero forces with
// force_applied clear. The block takes one beat every clock unless the output
// stalls; each result passes the 33-stage square root of the squared distance
// and the 47-stage divider, one result bit per stage. A stall at the output
// freezes the pipeline in the cycle after the first refused beat, which a
// one-entry skid holds. G is written through cfg_we_i/cfg_wdata_i as unsigned
// Q8.24 and resets to 1.0.
module pair_gravity_force (
  input  logic        clk_i,
  input  logic        rst_ni,
  pgf_in_if.sink      in_i,
  pgf_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import pgf_pkg::*;

  localparam int StD2  = 2;
  localparam int StNp  = 3;
  localparam int StNum = 4;
  localparam int StDsq = StNp + RootW;
  localparam int StDpp = StDsq + 1;
  localparam int StDen = StDpp + 1;
  localparam int StOvf = StDen + 1;
  localparam int StOut = StOvf + MagW + 1;
  localparam int NSt   = StOut + 1;

  typedef struct packed {
    logic            sx;
    logic            sy;
    logic            applied;
    logic            over_x;
    logic            over_y;
    logic [31:0]     ax;
    logic [31:0]     ay;
    logic [NumW-1:0] num_x;
    logic [NumW-1:0] num_y;
  } carry_t;

  typedef struct packed {
    logic [ForceW-1:0] f1x;
    logic [ForceW-1:0] f1y;
    logic [ForceW-1:0] f2x;
    logic [ForceW-1:0] f2y;
    logic              applied;
    logic              sat;
  } result_t;

  logic [31:0] g_q;
  logic        en;
  logic        skid_v_q;
  result_t     skid_q;
  result_t     res_q;
  result_t     res_d;
  logic [NSt-1:0] vld_q;

  carry_t cr_q [StOut];
  carry_t cr_d [StOut];

  logic [32:0]  dx;
  logic [32:0]  dy;
  logic [32:0]  adx;
  logic [32:0]  ady;
  logic [63:0]  p1_q;
  logic [31:0]  m2_q;
  logic [32:0]  rsum_q;
  logic [63:0]  ax2_q;
  logic [63:0]  ay2_q;
  logic [65:0]  s2_q;
  logic [63:0]  p2lo_q;
  logic [63:0]  p2hi_q;
  logic [64:0]  d2_sum;
  logic [64:0]  d2_q;
  logic [95:0]  p2_q;
  logic [63:0]  npx_q [3];
  logic [63:0]  npy_q [3];
  logic [127:0] numx_raw;
  logic [127:0] numy_raw;
  logic [RootW-1:0] root;
  logic [RootW-1:0] droot_q;
  logic [65:0]  dsq_q;
  logic [64:0]  dpp_q [3];
  logic [98:0]  d3;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] den_ovf_q;
  logic [MagW-1:0] qx;
  logic [MagW-1:0] qy;
  logic [MagW-1:0] magx;
  logic [MagW-1:0] magy;
  logic [ForceW-1:0] fx;
  logic [ForceW-1:0] fy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= GravReset;
    end else if (cfg_we_i) begin
      g_q <= cfg_wdata_i;
    end
  end

  assign en         = !skid_v_q;
  assign in_i.ready = en;

  // Valid bits travel with the data; a stall freezes every stage at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSt-2:0], in_i.valid};
    end
  end

  assign dx  = {in_i.second_x[31], in_i.second_x} - {in_i.first_x[31], in_i.first_x};
  assign dy  = {in_i.second_y[31], in_i.second_y} - {in_i.first_y[31], in_i.first_y};
  assign adx = dx[32] ? 33'(33'd0 - dx) : dx;
  assign ady = dy[32] ? 33'(33'd0 - dy) : dy;

  assign d2_sum   = 65'(ax2_q) + 65'(ay2_q);
  assign numx_raw = 128'(npx_q[0]) + {32'b0, npx_q[1], 32'b0} + {npx_q[2], 64'b0};
  assign numy_raw = 128'(npy_q[0]) + {32'b0, npy_q[1], 32'b0} + {npy_q[2], 64'b0};
  assign d3       = 99'(dpp_q[0]) + (99'(dpp_q[1]) << 32) + (99'(dpp_q[2]) << 64);

  always_comb begin
    cr_d[0]         = '0;
    cr_d[0].sx      = dx[32];
    cr_d[0].sy      = dy[32];
    cr_d[0].ax      = adx[31:0];
    cr_d[0].ay      = ady[31:0];
    for (int i = 1; i < StOut; i++) begin
      cr_d[i] = cr_q[i-1];
    end
    cr_d[StD2].applied = {1'b0, d2_sum} > s2_q;
    cr_d[StNum].num_x  = {numx_raw, {FracBits{1'b0}}};
    cr_d[StNum].num_y  = {numy_raw, {FracBits{1'b0}}};
    // A quotient of 2^47 or more clips, so the divider only needs 47 bits.
    cr_d[StOvf].over_x = CmpW'(cr_q[StOvf-1].num_x) >= {den_q, {MagW{1'b0}}};
    cr_d[StOvf].over_y = CmpW'(cr_q[StOvf-1].num_y) >= {den_q, {MagW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q      <= cr_d;
      p1_q      <= 64'(g_q) * 64'(in_i.first_mass);
      m2_q      <= in_i.second_mass;
      rsum_q    <= {1'b0, in_i.first_radius} + {1'b0, in_i.second_radius};
      ax2_q     <= 64'(cr_q[0].ax) * 64'(cr_q[0].ax);
      ay2_q     <= 64'(cr_q[0].ay) * 64'(cr_q[0].ay);
      s2_q      <= 66'(rsum_q) * 66'(rsum_q);
      p2lo_q    <= 64'(p1_q[31:0]) * 64'(m2_q);
      p2hi_q    <= 64'(p1_q[63:32]) * 64'(m2_q);
      d2_q      <= d2_sum;
      p2_q      <= 96'(p2lo_q) + {p2hi_q, 32'b0};
      for (int l = 0; l < 3; l++) begin
        npx_q[l] <= 64'(p2_q[32*l +: 32]) * 64'(cr_q[StD2].ax);
        npy_q[l] <= 64'(p2_q[32*l +: 32]) * 64'(cr_q[StD2].ay);
      end
      droot_q   <= root;
      dsq_q     <= 66'(root) * 66'(root);
      dpp_q[0]  <= 65'(dsq_q[31:0]) * 65'(droot_q);
      dpp_q[1]  <= 65'(dsq_q[63:32]) * 65'(droot_q);
      dpp_q[2]  <= 65'(dsq_q[65:64]) * 65'(droot_q);
      den_q     <= {d3, {GFrac{1'b0}}};
      den_ovf_q <= den_q;
      res_q     <= res_d;
    end
  end

  pgf_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (d2_q),
    .root_o (root)
  );

  pgf_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (cr_q[StOvf].num_x),
    .den_i  (den_ovf_q),
    .quot_o (qx)
  );

  pgf_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (cr_q[StOvf].num_y),
    .den_i  (den_ovf_q),
    .quot_o (qy)
  );

  assign magx = cr_q[StOut-1].over_x ? ForceMax : qx;
  assign magy = cr_q[StOut-1].over_y ? ForceMax : qy;
  assign fx   = cr_q[StOut-1].sx ? ForceW'(48'd0 - {1'b0, magx}) : {1'b0, magx};
  assign fy   = cr_q[StOut-1].sy ? ForceW'(48'd0 - {1'b0, magy}) : {1'b0, magy};

  always_comb begin
    res_d = '0;
    if (cr_q[StOut-1].applied) begin
      res_d.f1x     = fx;
      res_d.f1y     = fy;
      res_d.f2x     = ForceW'(48'd0 - fx);
      res_d.f2y     = ForceW'(48'd0 - fy);
      res_d.applied = 1'b1;
      res_d.sat     = cr_q[StOut-1].over_x | cr_q[StOut-1].over_y;
    end
  end

  // The skid catches the beat that is refused while the pipeline still moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (!skid_v_q) begin
      if (vld_q[StOut] && !out_o.ready) begin
        skid_v_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && vld_q[StOut] && !out_o.ready) begin
      skid_q <= res_q;
    end
  end

  result_t shown;
  assign shown               = skid_v_q ? skid_q : res_q;
  assign out_o.valid         = skid_v_q | vld_q[StOut];
  assign out_o.force_one_x   = shown.f1x;
  assign out_o.force_one_y   = shown.f1y;
  assign out_o.force_two_x   = shown.f2x;
  assign out_o.force_two_y   = shown.f2y;
  assign out_o.force_applied = shown.applied;
  assign out_o.saturated     = shown.sat;

  a_sat_needs_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!out_o.saturated || out_o.force_applied))
    else $error("saturation flagged on a pair without force");

  a_opposite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.force_two_x == ForceW'(48'd0 - out_o.force_one_x)) &&
                    (out_o.force_two_y == ForceW'(48'd0 - out_o.force_one_y)))
    else $error("force on body two is not the negation of body one");

  a_zero_when_touching: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.force_applied) |->
      (out_o.force_one_x == '0) && (out_o.force_one_y == '0))
    else $error("nonzero force on overlapping bodies");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_o.ready) |=> skid_v_q)
    else $error("skid dropped a refused beat");

  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[StOut-1]) |=> vld_q[StOut])
    else $error("beat lost before the output stage");

endmodule
`default_nettype wire
